@@ rtl/cccv_pkg.sv @@
`default_nettype none

package cccv_pkg;

  localparam int unsigned PwmMax   = 1350;
  localparam int unsigned PwmFloor = 50;
  localparam int unsigned SettleMs = 100;

  localparam int unsigned DutyW = 11;
  localparam int unsigned ModeW = 3;
  localparam int unsigned FuncW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DutyW-1:0] PWM_MAX   = DutyW'(PwmMax);
  localparam logic [DutyW-1:0] PWM_FLOOR = DutyW'(PwmFloor);
  localparam logic [31:0]      SETTLE_MS = 32'(SettleMs);

  localparam logic [ModeW-1:0] MODE_OFF  = 3'd0;
  localparam logic [ModeW-1:0] MODE_IDLE = 3'd1;
  localparam logic [ModeW-1:0] MODE_CONN = 3'd2;
  localparam logic [ModeW-1:0] MODE_CC   = 3'd3;
  localparam logic [ModeW-1:0] MODE_CV   = 3'd4;
  localparam logic [ModeW-1:0] MODE_END  = 3'd5;

  localparam logic [FuncW-1:0] FUNC_UPDATE  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_DISABLE = 2'd1;
  localparam logic [FuncW-1:0] FUNC_ENABLE  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_MIN_DOCKED  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CONNECT     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CUTOFF      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STORAGE     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_CURRENT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CV_CURRENT  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CV_SWITCH   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MAX_CHARGE  = 3'd7;

  typedef struct packed {
    logic [15:0] min_docked_mv;
    logic [15:0] connect_mv;
    logic [15:0] cutoff_mv;
    logic [15:0] storage_mv;
    logic [14:0] max_current_ma;
    logic [14:0] cv_current_ma;
    logic [15:0] cv_switch_mv;
    logic [15:0] max_charge_mv;
  } cfg_t;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [31:0]        now_ms;
    logic [15:0]        input_mv;
    logic [15:0]        battery_mv;
    logic [15:0]        charge_mv;
    logic signed [15:0] current_ma;
    logic signed [15:0] raw_current_ma;
  } item_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [DutyW-1:0] duty;
    logic             bus_enable;
    logic [31:0]      connect_time;
  } state_t;

  typedef struct packed {
    logic [DutyW-1:0]   pwm_duty;
    logic               hv_enable;
    logic [ModeW-1:0]   charge_mode;
    logic               offset_written;
    logic signed [15:0] offset_ma;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/cc_cv_charge_controller.sv @@
// CC/CV charge controller.
// Each item passes the input register, then the result register, before it reaches the outputs.
// Throughput: one item per cycle unless out_ready_i stalls; combinational step logic sets mode/duty.
// The result register lets a new item in while a finished result waits for out_ready_i.
// Reset: config registers take their default values, mode off, duty 0, bus off, no valid items.
`default_nettype none

module cc_cv_charge_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cccv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cccv_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [31:0]                   now_ms_i,
  input  wire logic [15:0]                   input_mv_i,
  input  wire logic [15:0]                   battery_mv_i,
  input  wire logic [15:0]                   charge_mv_i,
  input  wire logic signed [15:0]            current_ma_i,
  input  wire logic signed [15:0]            raw_current_ma_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [10:0]                        pwm_duty_o,
  output logic                               hv_enable_o,
  output logic [2:0]                         charge_mode_o,
  output logic                               offset_written_o,
  output logic signed [15:0]                 offset_ma_o
);

  cccv_pkg::cfg_t    cfg;
  cccv_pkg::item_t   s1_item_q;
  cccv_pkg::state_t  state_q, state_d;
  cccv_pkg::result_t res_d, res_q;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free, s1_move, in_xfer;

  assign cfg_ready_o = 1'b1;

  cccv_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_xfer || (s1_valid_q && !out_free);
  assign out_valid_d = s1_move || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.func           <= func_i;
      s1_item_q.now_ms         <= now_ms_i;
      s1_item_q.input_mv       <= input_mv_i;
      s1_item_q.battery_mv     <= battery_mv_i;
      s1_item_q.charge_mv      <= charge_mv_i;
      s1_item_q.current_ma     <= current_ma_i;
      s1_item_q.raw_current_ma <= raw_current_ma_i;
    end
    if (s1_move) begin
      res_q <= res_d;
    end
  end

  cccv_step u_step (
    .cfg_i   (cfg),
    .item_i  (s1_item_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      state_q.mode         <= cccv_pkg::MODE_OFF;
      state_q.duty         <= '0;
      state_q.bus_enable   <= 1'b0;
      state_q.connect_time <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_move) begin
        state_q <= state_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pwm_duty_o       = res_q.pwm_duty;
  assign hv_enable_o      = res_q.hv_enable;
  assign charge_mode_o    = res_q.charge_mode;
  assign offset_written_o = res_q.offset_written;
  assign offset_ma_o      = res_q.offset_ma;

  a_duty_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pwm_duty_o <= cccv_pkg::PWM_MAX)
    else $error("duty above cap");

  a_offset_cc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && offset_written_o) |->
      (charge_mode_o == cccv_pkg::MODE_CC && hv_enable_o))
    else $error("offset captured outside connect-to-cc transition");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_move |=> $stable(state_q))
    else $error("state changed without an item moving");

endmodule

`default_nettype wire

@@ rtl/cccv_cfg.sv @@
`default_nettype none

module cccv_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [cccv_pkg::CfgIdxW-1:0]  wr_index_i,
  input  wire logic [cccv_pkg::CfgDataW-1:0] wr_data_i,
  output cccv_pkg::cfg_t                     cfg_o
);

  cccv_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        cccv_pkg::REG_MIN_DOCKED:  cfg_d.min_docked_mv  = wr_data_i;
        cccv_pkg::REG_CONNECT:     cfg_d.connect_mv     = wr_data_i;
        cccv_pkg::REG_CUTOFF:      cfg_d.cutoff_mv      = wr_data_i;
        cccv_pkg::REG_STORAGE:     cfg_d.storage_mv     = wr_data_i;
        cccv_pkg::REG_MAX_CURRENT: cfg_d.max_current_ma = wr_data_i[14:0];
        cccv_pkg::REG_CV_CURRENT:  cfg_d.cv_current_ma  = wr_data_i[14:0];
        cccv_pkg::REG_CV_SWITCH:   cfg_d.cv_switch_mv   = wr_data_i;
        cccv_pkg::REG_MAX_CHARGE:  cfg_d.max_charge_mv  = wr_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_docked_mv  <= 16'd20000;
      cfg_q.connect_mv     <= 16'd30000;
      cfg_q.cutoff_mv      <= 16'd29000;
      cfg_q.storage_mv     <= 16'd26000;
      cfg_q.max_current_ma <= 15'd1500;
      cfg_q.cv_current_ma  <= 15'd150;
      cfg_q.cv_switch_mv   <= 16'd28000;
      cfg_q.max_charge_mv  <= 16'd29400;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/cccv_step.sv @@
`default_nettype none

module cccv_step (
  input  wire cccv_pkg::cfg_t    cfg_i,
  input  wire cccv_pkg::item_t   item_i,
  input  wire cccv_pkg::state_t  state_i,
  output cccv_pkg::state_t       state_o,
  output cccv_pkg::result_t      res_o
);

  logic signed [16:0] max_cur_s, cv_cur_s, cur_s;
  logic               bat_gt_cut, bat_lt_cut;
  logic [31:0]        elapsed;
  logic [cccv_pkg::ModeW-1:0] mode_eff;
  logic [cccv_pkg::DutyW-1:0] d1, d2;
  logic               wrote;

  assign max_cur_s  = $signed({2'b00, cfg_i.max_current_ma});
  assign cv_cur_s   = $signed({2'b00, cfg_i.cv_current_ma});
  assign cur_s      = $signed({item_i.current_ma[15], item_i.current_ma});
  assign bat_gt_cut = item_i.battery_mv > cfg_i.cutoff_mv;
  assign bat_lt_cut = item_i.battery_mv < cfg_i.cutoff_mv;
  assign elapsed    = item_i.now_ms - state_i.connect_time;

  always_comb begin
    state_o  = state_i;
    wrote    = 1'b0;
    d1       = state_i.duty;
    d2       = state_i.duty;
    mode_eff = state_i.mode;
    case (item_i.func)
      cccv_pkg::FUNC_DISABLE: state_o.mode = cccv_pkg::MODE_OFF;
      cccv_pkg::FUNC_ENABLE:  state_o.mode = cccv_pkg::MODE_IDLE;
      cccv_pkg::FUNC_UPDATE: begin
        if (item_i.input_mv < cfg_i.min_docked_mv) begin
          mode_eff = cccv_pkg::MODE_OFF;
        end
        state_o.mode = mode_eff;
        case (mode_eff)
          cccv_pkg::MODE_OFF: begin
            state_o.duty       = '0;
            state_o.bus_enable = 1'b0;
          end
          cccv_pkg::MODE_CONN: begin
            state_o.duty = '0;
            if (elapsed > cccv_pkg::SETTLE_MS) begin
              wrote              = 1'b1;
              state_o.bus_enable = 1'b1;
              state_o.mode       = cccv_pkg::MODE_CC;
            end
          end
          cccv_pkg::MODE_CC: begin
            if ((bat_gt_cut && state_i.duty != '0) ||
                (cur_s > max_cur_s && state_i.duty > cccv_pkg::PWM_FLOOR)) begin
              d1 = state_i.duty - 1'b1;
            end
            d2 = d1;
            if (bat_lt_cut && cur_s < max_cur_s && d1 < cccv_pkg::PWM_MAX) begin
              d2 = d1 + 1'b1;
            end
            state_o.duty = d2;
            if (item_i.charge_mv >= cfg_i.cv_switch_mv) begin
              state_o.mode = cccv_pkg::MODE_CV;
            end
          end
          cccv_pkg::MODE_CV: begin
            if (bat_lt_cut && item_i.charge_mv < cfg_i.max_charge_mv &&
                state_i.duty < cccv_pkg::PWM_MAX) begin
              d1 = state_i.duty + 1'b1;
            end
            d2 = d1;
            if ((bat_gt_cut && d1 != '0) ||
                (item_i.charge_mv > cfg_i.max_charge_mv && d1 > cccv_pkg::PWM_FLOOR)) begin
              d2 = d1 - 1'b1;
            end
            state_o.duty = d2;
            if (cur_s > cv_cur_s && d2 != '0) begin
              state_o.duty = d2 - 1'b1;
            end
            if (bat_gt_cut) begin
              state_o.mode = cccv_pkg::MODE_END;
            end
          end
          cccv_pkg::MODE_END: begin
            state_o.duty       = '0;
            state_o.bus_enable = 1'b0;
            if (item_i.battery_mv < cfg_i.storage_mv) begin
              state_o.mode = cccv_pkg::MODE_IDLE;
            end
          end
          default: begin
            if (item_i.input_mv >= cfg_i.connect_mv) begin
              state_o.mode         = cccv_pkg::MODE_CONN;
              state_o.bus_enable   = 1'b0;
              state_o.connect_time = item_i.now_ms;
            end
            state_o.duty = '0;
          end
        endcase
        if (state_o.duty > cccv_pkg::PWM_MAX) begin
          state_o.duty = cccv_pkg::PWM_MAX;
        end
      end
      default: state_o = state_i;
    endcase
  end

  always_comb begin
    res_o.pwm_duty       = state_o.duty;
    res_o.hv_enable      = state_o.bus_enable;
    res_o.charge_mode    = state_o.mode;
    res_o.offset_written = wrote;
    res_o.offset_ma      = wrote ? item_i.raw_current_ma : 16'sd0;
  end

endmodule

`default_nettype wire
